/* sv/assert_macros.svh */
// ----------------------------------------------------------------------------
// assert_macros.svh
// Shared assertion macros, clocked on clock and disabled during reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check an implication property on every rising edge outside reset
`define ASSERT_PROP(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// Check that a condition never holds outside reset
`define ASSERT_NEVER(lbl, cond, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) !(cond)) else $error(msg);

`endif

/* sv/kcft_pkg.sv */
// ----------------------------------------------------------------------------
// kcft_pkg
// Types and constants of the confirmation finality tracker.
// ----------------------------------------------------------------------------
package kcft_pkg;

   // Field widths
   localparam int NUM_W   = 32;
   localparam int SLOT_W  = 5;
   localparam int SCALE_W = 16;
   localparam int ACT_W   = 6;
   localparam int ADDR_W  = 2;
   localparam int REQ_DATA_W = 32;
   localparam int RSP_DATA_W = 40;

   // Quotient bits of the rank division (rank stays below 64)
   localparam int QUO_W  = 6;
   localparam int STEP_W = 3;
   localparam int PROD_W = SCALE_W + ACT_W;

   // Defaults
   localparam int DEF_MAX_PRODUCERS = 32;
   localparam logic [SCALE_W-1:0] DEF_FULL_SCALE = 16'd10000;
   localparam logic [SCALE_W-1:0] DEF_THRESHOLD  = 16'd7000;
   localparam logic [ACT_W-1:0]   DEF_ACTIVE     = 6'd21;

   // Register indexes
   localparam logic [ADDR_W-1:0] REG_FULL_SCALE = 2'd0;
   localparam logic [ADDR_W-1:0] REG_THRESHOLD  = 2'd1;
   localparam logic [ADDR_W-1:0] REG_ACTIVE     = 2'd2;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MUL,
      ST_DIV,
      ST_SCAN,
      ST_RESP
   } kcft_state_type;

endpackage

/* sv/kth_confirmation_finality_tracker.sv */
// ----------------------------------------------------------------------------
// kth_confirmation_finality_tracker
// Per-producer confirmed block table with rank selection of the finality number.
// ----------------------------------------------------------------------------
// Each request writes a confirmed block number into its producer's table entry,
// then the block finds the rank-th smallest entry among the n active slots,
// rank = (full_scale - finality_threshold) * n / full_scale clamped to n-1, and
// raises the finality number to it when larger. One request is handled at a
// time: an accept state, a multiply state, 6 restoring divide steps, then a
// scan in which two shared comparators visit each (candidate, entry) pair in
// turn, stopping at the first candidate that holds the rank, and then the
// response is handed over. A rejected slot goes from accept straight to the
// response state. The table sits in a memory with two registered read ports
// and valid bits that reset clears, so no clearing pass is needed.
// ----------------------------------------------------------------------------
module kth_confirmation_finality_tracker #(
   parameter int MAX_PRODUCERS = kcft_pkg::DEF_MAX_PRODUCERS
) (
   input  logic                            clock,
   input  logic                            reset,
   // request: tdata = confirmed_number[31:0]
   input  logic                            req_tvalid,
   output logic                            req_tready,
   input  logic [kcft_pkg::REQ_DATA_W-1:0] req_tdata,
   // request: tuser = producer_slot[4:0]
   input  logic [kcft_pkg::SLOT_W-1:0]     req_tuser,
   // response: tdata = final_number[31:0], advanced[32], slot_error[33], zero pad
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   output logic [kcft_pkg::RSP_DATA_W-1:0] rsp_tdata,
   // configuration write port
   input  logic                            csr_we,
   input  logic [kcft_pkg::ADDR_W-1:0]     csr_addr,
   input  logic [kcft_pkg::SCALE_W-1:0]    csr_wdata
);
   import kcft_pkg::*;

   `include "assert_macros.svh"

   localparam int IDX_W  = $clog2(MAX_PRODUCERS);
   localparam int CNT_W  = $clog2(MAX_PRODUCERS + 1);
   localparam int WIDE_W = (CNT_W > ACT_W) ? CNT_W : ACT_W;

   // Configuration registers
   logic [SCALE_W-1:0] full_scale_ff;
   logic [SCALE_W-1:0] threshold_ff;
   logic [ACT_W-1:0]   active_ff;

   // Table memory and its valid bits
   logic [NUM_W-1:0]         table_mem [MAX_PRODUCERS];
   logic [MAX_PRODUCERS-1:0] valid_ff;
   logic [NUM_W-1:0]         rd_a_ff;
   logic [NUM_W-1:0]         rd_b_ff;
   logic                     ok_a_ff;
   logic                     ok_b_ff;

   // Sequencer
   kcft_state_type     state_ff, state_in;
   logic [IDX_W-1:0]   i_ff, i_in;
   logic [IDX_W-1:0]   j_ff, j_in;
   logic [CNT_W-1:0]   less_ff, less_in;
   logic [CNT_W-1:0]   leq_ff, leq_in;
   logic [PROD_W-1:0]  rem_ff, rem_in;
   logic [QUO_W-1:0]   quo_ff, quo_in;
   logic [STEP_W-1:0]  step_ff, step_in;
   logic [NUM_W-1:0]   final_ff, final_in;
   logic               adv_ff, adv_in;
   logic               err_ff, err_in;

   // Combinational helpers
   logic [WIDE_W-1:0]  n_wide;
   logic [CNT_W-1:0]   n_cnt;
   logic [CNT_W-1:0]   n_m1;
   logic [SCALE_W-1:0] diff;
   logic [PROD_W-1:0]  trial;
   logic [WIDE_W-1:0]  rank_w;
   logic [NUM_W-1:0]   val_a;
   logic [NUM_W-1:0]   val_b;
   logic [NUM_W-1:0]   pick;
   logic               found;
   logic               slot_bad;
   logic               req_acc;
   logic               wr_en;

   // Active slot count saturated to the table size
   always_comb begin
      if (WIDE_W'(active_ff) > WIDE_W'(MAX_PRODUCERS)) begin
         n_wide = WIDE_W'(MAX_PRODUCERS);
      end else begin
         n_wide = WIDE_W'(active_ff);
      end
   end
   assign n_cnt = CNT_W'(n_wide);
   assign n_m1  = n_cnt - CNT_W'(1);

   assign diff     = (threshold_ff >= full_scale_ff) ? '0 : full_scale_ff - threshold_ff;
   assign trial    = PROD_W'(full_scale_ff) << step_ff;
   assign rank_w   = (WIDE_W'(quo_ff) > WIDE_W'(n_m1)) ? WIDE_W'(n_m1) : WIDE_W'(quo_ff);
   assign val_a    = ok_a_ff ? rd_a_ff : '0;
   assign val_b    = ok_b_ff ? rd_b_ff : '0;
   assign slot_bad = WIDE_W'(req_tuser) >= n_wide;
   assign req_acc  = req_tvalid && req_tready;
   assign wr_en    = req_acc && !slot_bad;

   // Configuration writes; an index past the last register is dropped
   always_ff @(posedge clock) begin
      if (reset) begin
         full_scale_ff <= DEF_FULL_SCALE;
         threshold_ff  <= DEF_THRESHOLD;
         active_ff     <= DEF_ACTIVE;
      end else if (csr_we) begin
         case (csr_addr)
            REG_FULL_SCALE: full_scale_ff <= csr_wdata;
            REG_THRESHOLD:  threshold_ff  <= csr_wdata;
            REG_ACTIVE:     active_ff     <= csr_wdata[ACT_W-1:0];
            default:        ;
         endcase
      end
   end

   // Table write and registered reads at the next scan addresses
   always_ff @(posedge clock) begin
      if (wr_en) begin
         table_mem[IDX_W'(req_tuser)] <= req_tdata[NUM_W-1:0];
      end
      rd_a_ff <= table_mem[i_in];
      rd_b_ff <= table_mem[j_in];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
         ok_a_ff  <= 1'b0;
         ok_b_ff  <= 1'b0;
      end else begin
         if (wr_en) begin
            valid_ff[IDX_W'(req_tuser)] <= 1'b1;
         end
         ok_a_ff <= valid_ff[i_in];
         ok_b_ff <= valid_ff[j_in];
      end
   end

   // State and working registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         final_ff <= '0;
         adv_ff   <= 1'b0;
         err_ff   <= 1'b0;
         i_ff     <= '0;
         j_ff     <= '0;
      end else begin
         state_ff <= state_in;
         final_ff <= final_in;
         adv_ff   <= adv_in;
         err_ff   <= err_in;
         i_ff     <= i_in;
         j_ff     <= j_in;
      end
   end

   always_ff @(posedge clock) begin
      less_ff <= less_in;
      leq_ff  <= leq_in;
      rem_ff  <= rem_in;
      quo_ff  <= quo_in;
      step_ff <= step_in;
   end

   // Sequencer: multiply, divide for the rank, then scan candidates
   always_comb begin
      state_in = state_ff;
      i_in     = i_ff;
      j_in     = j_ff;
      less_in  = less_ff;
      leq_in   = leq_ff;
      rem_in   = rem_ff;
      quo_in   = quo_ff;
      step_in  = step_ff;
      final_in = final_ff;
      adv_in   = adv_ff;
      err_in   = err_ff;
      found    = 1'b0;
      pick     = '0;
      case (state_ff)
         ST_IDLE: begin
            if (req_acc) begin
               i_in   = '0;
               j_in   = '0;
               adv_in = 1'b0;
               err_in = slot_bad;
               state_in = slot_bad ? ST_RESP : ST_MUL;
            end
         end
         ST_MUL: begin
            rem_in   = PROD_W'(diff) * PROD_W'(n_wide[ACT_W-1:0]);
            quo_in   = '0;
            step_in  = STEP_W'(QUO_W - 1);
            state_in = ST_DIV;
         end
         ST_DIV: begin
            // one restoring step per cycle, quotient bit step_ff
            if ((full_scale_ff != '0) && (rem_ff >= trial)) begin
               rem_in = rem_ff - trial;
               quo_in[step_ff] = 1'b1;
            end
            if (step_ff == '0) begin
               less_in  = '0;
               leq_in   = '0;
               state_in = ST_SCAN;
            end else begin
               step_in = step_ff - STEP_W'(1);
            end
         end
         ST_SCAN: begin
            // count entries below and not above the current candidate
            less_in = less_ff + CNT_W'(val_b < val_a);
            leq_in  = leq_ff + CNT_W'(val_b <= val_a);
            if (CNT_W'(j_ff) == n_m1) begin
               found = (WIDE_W'(less_in) <= rank_w) && (rank_w < WIDE_W'(leq_in));
               if (found || (CNT_W'(i_ff) == n_m1)) begin
                  pick = found ? val_a : '0;
                  if (pick > final_ff) begin
                     final_in = pick;
                     adv_in   = 1'b1;
                  end
                  state_in = ST_RESP;
               end else begin
                  i_in    = i_ff + IDX_W'(1);
                  j_in    = '0;
                  less_in = '0;
                  leq_in  = '0;
               end
            end else begin
               j_in = j_ff + IDX_W'(1);
            end
         end
         ST_RESP: begin
            if (rsp_tready) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = (state_ff == ST_RESP);
   assign rsp_tdata  = {(RSP_DATA_W - NUM_W - 2)'(0), err_ff, adv_ff, final_ff};

   // Checks
   `ASSERT_PROP(a_final_monotonic, !$past(reset) |-> final_ff >= $past(final_ff), "finality number decreased")
   `ASSERT_NEVER(a_adv_with_err, rsp_tvalid && adv_ff && err_ff, "advance reported on a rejected slot")
   `ASSERT_PROP(a_scan_in_range, (state_ff == ST_SCAN) |-> (CNT_W'(i_ff) < n_cnt) && (CNT_W'(j_ff) < n_cnt), "scan index beyond active slots")
   `ASSERT_PROP(a_err_keeps_final, (req_acc && slot_bad) |=> $stable(final_ff), "rejected slot changed finality number")

endmodule
